/* rtl/grcm_pkg.sv */
// ----------------------------------------------------------------------------
// grcm_pkg
// Shared types, constants and elaboration-time helpers for the color mapper.
// ----------------------------------------------------------------------------
package grcm_pkg;

    localparam int Q30_W        = 31;                  // Q0.30 value incl. 1.0
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam int P_W          = 21;                  // exponent p, Q5.16
    localparam int P_FRAC       = 16;
    localparam int EXP_STEPS    = 16;
    localparam int LOG_STEPS    = 16;
    localparam int D_W          = 29;                  // (1-contrast)*gamma, Q.24
    localparam int RNG_NUM_W    = 46;
    localparam int RNG_DEN_W    = 16;
    localparam logic [4:0] IP_MAX = 5'd31;

    typedef enum logic [2:0] {
        REG_START_COLOR = 3'd0,
        REG_END_COLOR   = 3'd1,
        REG_RANGE       = 3'd2,
        REG_CONTRAST    = 3'd3,
        REG_GAMMA       = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [RNG_NUM_W-1:0] num;
        logic [RNG_DEN_W-1:0] den;
    } t_prep;

    // 2^(-2^-k) in Q0.30: k successive integer square roots starting at 0.5
    function automatic logic [29:0] exp_fac(input int k);
        logic [63:0] f;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        f = 64'h2000_0000;
        for (int j = 0; j < k; j++) begin
            v = f << 30;
            r = '0;
            b = 64'h4000_0000_0000_0000;
            for (int i = 0; i < 32; i++) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            f = r;
        end
        return f[29:0];
    endfunction

endpackage

/* rtl/grcm_div.sv */
// ----------------------------------------------------------------------------
// grcm_div
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
// ----------------------------------------------------------------------------
module grcm_div #(
    parameter int NUM_W  = 46,
    parameter int DEN_W  = 16,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q_W-1:0]    o_quo,
    output logic              o_ovf,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [Q_W+1];
    logic [DEN_W-1:0]  r_rem  [Q_W+1];
    logic [DEN_W-1:0]  r_den  [Q_W+1];
    logic [Q_W-1:0]    r_low  [Q_W+1];
    logic [Q_W-1:0]    r_quo  [Q_W+1];
    logic              r_ovf  [Q_W+1];
    logic [SIDE_W-1:0] r_side [Q_W+1];

    wire [DEN_W-1:0] w_rem [1:Q_W];
    wire [Q_W-1:0]   w_low [1:Q_W];
    wire [Q_W-1:0]   w_quo [1:Q_W];
    wire             w_ovf0;

    // quotient would not fit in Q_W bits
    assign w_ovf0 = (i_num >> Q_W) >= NUM_W'(i_den);

    for (genvar j = 1; j <= Q_W; j++) begin : g_stage
        wire [DEN_W:0] w_t  = {r_rem[j-1], r_low[j-1][Q_W-1]};
        wire           w_ge = w_t >= {1'b0, r_den[j-1]};
        wire [DEN_W:0] w_d  = w_t - {1'b0, r_den[j-1]};
        assign w_rem[j] = w_ge ? w_d[DEN_W-1:0] : w_t[DEN_W-1:0];
        assign w_low[j] = r_low[j-1] << 1;
        assign w_quo[j] = {r_quo[j-1][Q_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= Q_W; j++) r_vld[j] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int j = 1; j <= Q_W; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= DEN_W'(i_num >> Q_W);
        r_low[0]  <= i_num[Q_W-1:0];
        r_quo[0]  <= '0;
        r_ovf[0]  <= w_ovf0;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int j = 1; j <= Q_W; j++) begin
            r_rem[j]  <= w_rem[j];
            r_low[j]  <= w_low[j];
            r_quo[j]  <= w_quo[j];
            r_ovf[j]  <= r_ovf[j-1];
            r_den[j]  <= r_den[j-1];
            r_side[j] <= r_side[j-1];
        end
    end

    assign o_vld  = r_vld[Q_W];
    assign o_quo  = r_quo[Q_W];
    assign o_ovf  = r_ovf[Q_W];
    assign o_side = r_side[Q_W];

endmodule

/* rtl/grcm_log2.sv */
// ----------------------------------------------------------------------------
// grcm_log2
// Pipelined log2 of the index: normalize, then one squaring per stage.
// ----------------------------------------------------------------------------
module grcm_log2 import grcm_pkg::*; #(
    parameter int LEVEL_BITS = 16,
    parameter int SIDE_W     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [LEVEL_BITS-1:0]         i_idx,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_vld,
    output logic [$clog2(LEVEL_BITS)-1:0] o_n,
    output logic [LOG_STEPS-1:0]          o_frac,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int NW = $clog2(LEVEL_BITS);

    logic                 r_vld  [LOG_STEPS+1];
    logic [Q30_W-1:0]     r_x    [LOG_STEPS+1];
    logic [LOG_STEPS-1:0] r_frac [LOG_STEPS+1];
    logic [NW-1:0]        r_n    [LOG_STEPS+1];
    logic [SIDE_W-1:0]    r_side [LOG_STEPS+1];

    logic [NW-1:0]    w_n0;
    logic [Q30_W-1:0] w_x0;

    wire [Q30_W-1:0]     w_x    [1:LOG_STEPS];
    wire [LOG_STEPS-1:0] w_frac [1:LOG_STEPS];

    // leading-one position and mantissa in [1,2) as Q1.30
    always_comb begin
        w_n0 = '0;
        for (int i = 0; i < LEVEL_BITS; i++) begin
            if (i_idx[i]) w_n0 = NW'(i);
        end
        w_x0 = Q30_W'(i_idx) << (5'd30 - 5'(w_n0));
    end

    for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_sq
        wire [2*Q30_W-1:0] w_sq = r_x[k-1] * r_x[k-1];
        wire [31:0]        w_y  = w_sq[61:30];
        assign w_x[k]    = w_y[31] ? w_y[31:1] : w_y[30:0];
        assign w_frac[k] = {r_frac[k-1][LOG_STEPS-2:0], w_y[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LOG_STEPS; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 1; k <= LOG_STEPS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= w_x0;
        r_frac[0] <= '0;
        r_n[0]    <= w_n0;
        r_side[0] <= i_side;
        for (int k = 1; k <= LOG_STEPS; k++) begin
            r_x[k]    <= w_x[k];
            r_frac[k] <= w_frac[k];
            r_n[k]    <= r_n[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_vld  = r_vld[LOG_STEPS];
    assign o_n    = r_n[LOG_STEPS];
    assign o_frac = r_frac[LOG_STEPS];
    assign o_side = r_side[LOG_STEPS];

endmodule

/* rtl/grcm_exp2.sv */
// ----------------------------------------------------------------------------
// grcm_exp2
// Pipelined 2^-p in Q0.30: one constant factor per fraction bit, then shift.
// ----------------------------------------------------------------------------
module grcm_exp2 import grcm_pkg::*; #(
    parameter int SIDE_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [P_W-1:0]    i_p,
    input  logic              i_zero,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q30_W-1:0]  o_light,
    output logic [SIDE_W-1:0] o_side
);

    logic                 r_vld  [EXP_STEPS+1];
    logic [Q30_W-1:0]     r_r    [EXP_STEPS+1];
    logic [P_FRAC-1:0]    r_f    [EXP_STEPS+1];
    logic [4:0]           r_ip   [EXP_STEPS+1];
    logic                 r_z    [EXP_STEPS+1];
    logic [SIDE_W-1:0]    r_side [EXP_STEPS+1];

    logic              r_out_vld;
    logic [Q30_W-1:0]  r_out_light;
    logic [SIDE_W-1:0] r_out_side;

    wire [Q30_W-1:0] w_r [1:EXP_STEPS];

    for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_mul
        localparam logic [29:0] FAC = exp_fac(k);
        wire [60:0] w_prod = r_r[k-1] * FAC;
        assign w_r[k] = r_f[k-1][P_FRAC-k] ? w_prod[60:30] : r_r[k-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= EXP_STEPS; k++) r_vld[k] <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 1; k <= EXP_STEPS; k++) r_vld[k] <= r_vld[k-1];
            r_out_vld <= r_vld[EXP_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_r[0]    <= ONE_Q30;
        r_f[0]    <= i_p[P_FRAC-1:0];
        r_ip[0]   <= i_p[P_W-1:P_FRAC];
        r_z[0]    <= i_zero || (i_p[P_W-1:P_FRAC] >= IP_MAX);
        r_side[0] <= i_side;
        for (int k = 1; k <= EXP_STEPS; k++) begin
            r_r[k]    <= w_r[k];
            r_f[k]    <= r_f[k-1];
            r_ip[k]   <= r_ip[k-1];
            r_z[k]    <= r_z[k-1];
            r_side[k] <= r_side[k-1];
        end
        r_out_light <= r_z[EXP_STEPS] ? '0 : (r_r[EXP_STEPS] >> r_ip[EXP_STEPS]);
        r_out_side  <= r_side[EXP_STEPS];
    end

    assign o_vld   = r_out_vld;
    assign o_light = r_out_light;
    assign o_side  = r_out_side;

endmodule

/* rtl/grcm_sqrt.sv */
// ----------------------------------------------------------------------------
// grcm_sqrt
// Pipelined isqrt(v << 30) of a Q0.30 position, one root bit per stage.
// ----------------------------------------------------------------------------
module grcm_sqrt import grcm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [Q30_W-1:0] i_v,
    output logic             o_vld,
    output logic [Q30_W-1:0] o_root
);

    localparam int RW = 2 * Q30_W;

    logic             r_vld  [Q30_W+1];
    logic [RW-1:0]    r_rem  [Q30_W+1];
    logic [Q30_W-1:0] r_root [Q30_W+1];

    wire [RW-1:0]    w_rem  [1:Q30_W];
    wire [Q30_W-1:0] w_root [1:Q30_W];

    for (genvar j = 1; j <= Q30_W; j++) begin : g_bit
        localparam int B = Q30_W - j;
        wire [RW-1:0] w_trial = (RW'(r_root[j-1]) << (B + 1)) + (RW'(1) << (2 * B));
        wire          w_ge    = w_trial <= r_rem[j-1];
        assign w_rem[j]  = w_ge ? (r_rem[j-1] - w_trial) : r_rem[j-1];
        assign w_root[j] = w_ge ? (r_root[j-1] | (Q30_W'(1) << B)) : r_root[j-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= Q30_W; j++) r_vld[j] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int j = 1; j <= Q30_W; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= {1'b0, i_v, 30'b0};
        r_root[0] <= '0;
        for (int j = 1; j <= Q30_W; j++) begin
            r_rem[j]  <= w_rem[j];
            r_root[j] <= w_root[j];
        end
    end

    assign o_vld  = r_vld[Q30_W];
    assign o_root = r_root[Q30_W];

endmodule

/* rtl/gamma_range_color_map.sv */
// ----------------------------------------------------------------------------
// gamma_range_color_map
// Level to RGBA color: gamma, range and square-root shaping, blend, no table.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+--------------------
//  level in | in        | start (busy is always low)  | i_level[16:0]
//  color out| out       | o_strobe, one cycle         | o_rgba[31:0]
//  config   | in/out    | APB psel/penable/pwrite     | paddr, pwdata, prdata
//
//  One word enters per clock; the pipeline is fully stalled by nothing.
//  Register stages: index (1), log2 (17), numerator (1), exponent
//  divider (22), exp2 (18), range prep (1), range divider (32), clamp
//  (1), square root (32), blend (1), output (1). The length is set by
//  the bit-per-stage dividers and square roots. Reset (i_rst_n low,
//  synchronous) drops all words in flight and loads the register
//  defaults. Config writes are only legal while idle.
// ----------------------------------------------------------------------------
module gamma_range_color_map import grcm_pkg::*; #(
    parameter int LEVEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // level in
    input  logic        start,
    output logic        busy,
    input  logic [16:0] i_level,
    // color out
    output logic        o_strobe,
    output logic [31:0] o_rgba,
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NW  = $clog2(LEVEL_BITS);
    localparam int MW  = NW + 17;              // m = -log2(u), Q.16
    localparam int PNW = MW + 24;              // m << 24
    localparam logic [MW-1:0] M_TOP = MW'(LEVEL_BITS) << 16;

    // ---------------- configuration registers ----------------
    logic [31:0]        r_start_color;
    logic [31:0]        r_end_color;
    logic signed [15:0] r_range_q15;
    logic [15:0]        r_contrast_q16;
    logic [11:0]        r_gamma_q8;
    logic [D_W-1:0]     r_d;                   // (1-c)*g, Q.24

    wire w_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_color  <= 32'h0000_0000;
            r_end_color    <= 32'hFFFF_FFFF;
            r_range_q15    <= 16'sd0;
            r_contrast_q16 <= 16'd32768;
            r_gamma_q8     <= 12'd512;
        end else if (w_wr) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_START_COLOR: r_start_color  <= pwdata;
                REG_END_COLOR:   r_end_color    <= pwdata;
                REG_RANGE:       r_range_q15    <= pwdata[15:0];
                REG_CONTRAST:    r_contrast_q16 <= pwdata[15:0];
                REG_GAMMA:       r_gamma_q8     <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // exponent divisor, refreshed every cycle from the static registers
    always_ff @(posedge i_clk) begin
        r_d <= D_W'(17'h1_0000 - {1'b0, r_contrast_q16}) * D_W'(r_gamma_q8);
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_START_COLOR: prdata = r_start_color;
            REG_END_COLOR:   prdata = r_end_color;
            REG_RANGE:       prdata = {16'b0, r_range_q15};
            REG_CONTRAST:    prdata = {16'b0, r_contrast_q16};
            REG_GAMMA:       prdata = {20'b0, r_gamma_q8};
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // ---------------- S1: quantize level to index ----------------
    logic                  r_s1_vld;
    logic [LEVEL_BITS-1:0] r_s1_idx;
    logic [16:0]           w_lvl;
    logic [LEVEL_BITS+16:0] w_iprod;

    always_comb begin
        w_lvl   = (i_level > 17'h1_0000) ? 17'h1_0000 : i_level;
        w_iprod = w_lvl * (LEVEL_BITS + 17)'((1 << LEVEL_BITS) - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_vld <= 1'b0;
        else          r_s1_vld <= start && !busy;
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= w_iprod[16 +: LEVEL_BITS];
    end

    // ---------------- log2 of the index ----------------
    logic                  w_lg_vld;
    logic [NW-1:0]         w_lg_n;
    logic [LOG_STEPS-1:0]  w_lg_frac;
    logic [LEVEL_BITS-1:0] w_lg_idx;

    grcm_log2 #(
        .LEVEL_BITS (LEVEL_BITS),
        .SIDE_W     (LEVEL_BITS)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s1_vld),
        .i_idx   (r_s1_idx),
        .i_side  (r_s1_idx),
        .o_vld   (w_lg_vld),
        .o_n     (w_lg_n),
        .o_frac  (w_lg_frac),
        .o_side  (w_lg_idx)
    );

    // ---------------- S2: -log2(u) and exponent numerator ----------------
    logic                  r_s2_vld;
    logic [PNW-1:0]        r_s2_num;
    logic                  r_s2_zero;
    logic [LEVEL_BITS-1:0] r_s2_idx;
    logic [MW-1:0]         w_m;

    assign w_m = M_TOP - MW'({w_lg_n, w_lg_frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_vld <= 1'b0;
        else          r_s2_vld <= w_lg_vld;
    end

    always_ff @(posedge i_clk) begin
        r_s2_num  <= {w_m, 24'b0};
        // zero index or zero gamma: lightness is zero before range
        r_s2_zero <= (w_lg_idx == '0) || (r_d == '0);
        r_s2_idx  <= w_lg_idx;
    end

    // ---------------- p = (m << 24) / d ----------------
    logic                  w_pd_vld;
    logic [P_W-1:0]        w_pd_quo;
    logic                  w_pd_ovf;
    logic [LEVEL_BITS:0]   w_pd_side;

    grcm_div #(
        .NUM_W  (PNW),
        .DEN_W  (D_W),
        .Q_W    (P_W),
        .SIDE_W (LEVEL_BITS + 1)
    ) u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_vld),
        .i_num   (r_s2_num),
        .i_den   (r_d),
        .i_side  ({r_s2_zero, r_s2_idx}),
        .o_vld   (w_pd_vld),
        .o_quo   (w_pd_quo),
        .o_ovf   (w_pd_ovf),
        .o_side  (w_pd_side)
    );

    // ---------------- lightness = 2^-p ----------------
    logic                  w_ex_vld;
    logic [Q30_W-1:0]      w_ex_light;
    logic [LEVEL_BITS-1:0] w_ex_idx;

    grcm_exp2 #(
        .SIDE_W (LEVEL_BITS)
    ) u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_pd_vld),
        .i_p     (w_pd_quo),
        .i_zero  (w_pd_side[LEVEL_BITS] || w_pd_ovf),
        .i_side  (w_pd_side[LEVEL_BITS-1:0]),
        .o_vld   (w_ex_vld),
        .o_light (w_ex_light),
        .o_side  (w_ex_idx)
    );

    // ---------------- S3: range mapping operands ----------------
    // r > 0: x / (1-r); r <= 0: (x + r) / (1 + r), zero when not positive
    function automatic t_prep range_prep(input logic [Q30_W-1:0] x,
                                         input logic signed [15:0] rq);
        logic signed [47:0] nums;
        logic signed [16:0] dens;
        t_prep res;
        if (rq > 16'sd0) begin
            dens    = 17'sd32768 - 17'(rq);
            res.num = {x, 15'b0};
            res.den = dens[15:0];
        end else begin
            dens = 17'sd32768 + 17'(rq);
            nums = $signed({2'b0, x, 15'b0}) + ($signed(48'(rq)) <<< 30);
            if (dens == 17'sd0 || nums <= 48'sd0) begin
                res.num = '0;
                res.den = 16'd1;
            end else begin
                res.num = nums[RNG_NUM_W-1:0];
                res.den = dens[15:0];
            end
        end
        return res;
    endfunction

    logic       r_s3_vld;
    t_prep      r_s3_hue;
    t_prep      r_s3_light;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_vld <= 1'b0;
        else          r_s3_vld <= w_ex_vld;
    end

    always_ff @(posedge i_clk) begin
        r_s3_hue   <= range_prep(Q30_W'(w_ex_idx) << (30 - LEVEL_BITS), r_range_q15);
        r_s3_light <= range_prep(w_ex_light, r_range_q15);
    end

    // ---------------- range dividers, one per path ----------------
    logic             w_hd_vld, w_ld_vld;
    logic [Q30_W-1:0] w_hd_quo, w_ld_quo;
    logic             w_hd_ovf, w_ld_ovf;

    grcm_div #(
        .NUM_W  (RNG_NUM_W),
        .DEN_W  (RNG_DEN_W),
        .Q_W    (Q30_W),
        .SIDE_W (1)
    ) u_hdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s3_vld),
        .i_num   (r_s3_hue.num),
        .i_den   (r_s3_hue.den),
        .i_side  (1'b0),
        .o_vld   (w_hd_vld),
        .o_quo   (w_hd_quo),
        .o_ovf   (w_hd_ovf),
        .o_side  ()
    );

    grcm_div #(
        .NUM_W  (RNG_NUM_W),
        .DEN_W  (RNG_DEN_W),
        .Q_W    (Q30_W),
        .SIDE_W (1)
    ) u_ldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s3_vld),
        .i_num   (r_s3_light.num),
        .i_den   (r_s3_light.den),
        .i_side  (1'b0),
        .o_vld   (w_ld_vld),
        .o_quo   (w_ld_quo),
        .o_ovf   (w_ld_ovf),
        .o_side  ()
    );

    // ---------------- S4: clamp to 1.0 ----------------
    logic             r_s4_vld;
    logic [Q30_W-1:0] r_s4_vh;
    logic [Q30_W-1:0] r_s4_vl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4_vld <= 1'b0;
        else          r_s4_vld <= w_hd_vld;
    end

    always_ff @(posedge i_clk) begin
        r_s4_vh <= (w_hd_ovf || w_hd_quo > ONE_Q30) ? ONE_Q30 : w_hd_quo;
        r_s4_vl <= (w_ld_ovf || w_ld_quo > ONE_Q30) ? ONE_Q30 : w_ld_quo;
    end

    // ---------------- square roots ----------------
    logic             w_hs_vld, w_ls_vld;
    logic [Q30_W-1:0] w_sh, w_sl;

    grcm_sqrt u_hsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s4_vld),
        .i_v     (r_s4_vh),
        .o_vld   (w_hs_vld),
        .o_root  (w_sh)
    );

    grcm_sqrt u_lsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s4_vld),
        .i_v     (r_s4_vl),
        .o_vld   (w_ls_vld),
        .o_root  (w_sl)
    );

    // ---------------- S5: blend start -> end at hue position ----------------
    logic             r_s5_vld;
    logic [7:0]       r_s5_c [4];
    logic [Q30_W-1:0] r_s5_sl;
    logic [7:0]       w_c [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [38:0] sum;
            sum = 39'(ONE_Q30 - w_sh) * 39'(r_start_color[8*k +: 8])
                + 39'(w_sh) * 39'(r_end_color[8*k +: 8]);
            w_c[k] = sum[37:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s5_vld <= 1'b0;
        else          r_s5_vld <= w_hs_vld;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) r_s5_c[k] <= w_c[k];
        r_s5_sl <= w_sl;
    end

    // ---------------- S6: lightness scale on RGB, output register ----------------
    logic        r_strobe;
    logic [31:0] r_rgba;
    logic [31:0] w_rgba;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [38:0] p;
            p = r_s5_sl * r_s5_c[k];
            w_rgba[8*k +: 8] = p[37:30];
        end
        w_rgba[31:24] = r_s5_c[3];          // alpha is not scaled
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= r_s5_vld;
    end

    always_ff @(posedge i_clk) begin
        r_rgba <= w_rgba;
    end

    assign o_strobe = r_strobe;
    assign o_rgba   = r_rgba;

    // ---------------- assertions ----------------
    a_div_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hd_vld == w_ld_vld)
        else $error("range dividers out of step");

    a_sqrt_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hs_vld == w_ls_vld)
        else $error("square roots out of step");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld |-> (r_s4_vh <= ONE_Q30 && r_s4_vl <= ONE_Q30))
        else $error("clamped position above one");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

endmodule
